// ===== hdl/cpcc_pkg.sv =====
// shared types and constants of the coil pulse and cooldown controller
package cpcc_pkg;

  localparam int CH_W       = 4;
  localparam int TICK_W     = 15;
  localparam int CNT_W      = 16;
  localparam int DRIVE_W    = 16;
  localparam int MASK_W     = 16;
  localparam int TDATA_W    = 40;
  localparam int TUSER_W    = 2;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_PAIR_MASK = '0;

  typedef enum logic [TUSER_W-1:0] {
    KIND_TICK   = 2'd0,
    KIND_SINGLE = 2'd1,
    KIND_PAIR   = 2'd2,
    KIND_TIMING = 2'd3
  } kind_t;

  typedef struct packed {
    logic [TICK_W-1:0] active_ticks;
    logic [TICK_W-1:0] cooldown_ticks;
    logic              request;
    logic [CH_W-1:0]   channel;
  } item_t;

  localparam int ITEM_W = $bits(item_t);

endpackage

// ===== hdl/cpcc_regs.sv =====
// configuration register block with the flipper pair mask
module cpcc_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cpcc_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [cpcc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [cpcc_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output logic [cpcc_pkg::MASK_W-1:0]         flipper_pair_mask
);

  logic [cpcc_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           hit;

  assign reg_idx = paddr[cpcc_pkg::APB_ADDR_W-1:2];
  assign hit     = (reg_idx == cpcc_pkg::REG_PAIR_MASK);
  assign pready  = 1'b1;
  assign prdata  = hit ? cpcc_pkg::APB_DATA_W'(flipper_pair_mask) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      flipper_pair_mask <= '0;
    end else if (psel && penable && pwrite && pready && hit) begin
      flipper_pair_mask <= pwdata[cpcc_pkg::MASK_W-1:0];
    end
  end

endmodule

// ===== hdl/coil_pulse_cooldown_controller_top.sv =====
// top level of the coil pulse and cooldown controller
// Takes one item per clock while the output is not stalled and returns one coil_drive
// item per input item. An accepted item sits in an input register, where the addressed
// channel's counter and timing entry are checked; when it advances, every per-coil
// counter and the drive bits update, and the resulting drive bits land in the output
// register. The input side keeps accepting while the output register drains, so a stalled
// output holds at most two items in flight. The user must write the flipper pair mask
// through the register port at byte address 0 while no items are in flight; not enforced.
module coil_pulse_cooldown_controller_top #(
  parameter int NUM_COILS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // channel, request, cooldown_ticks, active_ticks, zero fill
  input  logic [cpcc_pkg::TDATA_W-1:0]        s_axis_tdata,
  // kind
  input  logic [cpcc_pkg::TUSER_W-1:0]        s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // coil_drive
  output logic [cpcc_pkg::DRIVE_W-1:0]        m_axis_tdata,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cpcc_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [cpcc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [cpcc_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int IDX_W = (NUM_COILS > 1) ? $clog2(NUM_COILS) : 1;
  localparam int CW    = ((IDX_W > cpcc_pkg::CH_W) ? IDX_W : cpcc_pkg::CH_W) + 1;
  localparam int DW    = (NUM_COILS > cpcc_pkg::DRIVE_W) ? NUM_COILS : cpcc_pkg::DRIVE_W;

  logic [cpcc_pkg::MASK_W-1:0] flipper_pair_mask;

  cpcc_regs u_regs (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .flipper_pair_mask (flipper_pair_mask)
  );

  // input register
  logic                item_valid;
  cpcc_pkg::item_t     item;
  cpcc_pkg::kind_t     kind;
  logic                advance;

  assign advance       = item_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      item <= cpcc_pkg::item_t'(s_axis_tdata[cpcc_pkg::ITEM_W-1:0]);
      kind <= cpcc_pkg::kind_t'(s_axis_tuser);
    end
  end

  // per-coil state
  logic [cpcc_pkg::CNT_W-1:0]  counter       [NUM_COILS];
  logic [cpcc_pkg::CNT_W-1:0]  counter_next  [NUM_COILS];
  logic [cpcc_pkg::TICK_W-1:0] cooldown_tbl  [NUM_COILS];
  logic [cpcc_pkg::TICK_W-1:0] active_tbl    [NUM_COILS];
  logic [NUM_COILS-1:0]        drive;
  logic [NUM_COILS-1:0]        drive_next;

  logic [CW-1:0]               ch_ext;
  logic                        ch_ok;
  logic                        hold_ok;
  logic [IDX_W-1:0]            idx;
  logic [IDX_W-1:0]            hidx;
  logic                        is_check;
  logic                        pair_ok;
  logic [cpcc_pkg::CNT_W-1:0]  cnt_sel;
  logic [cpcc_pkg::TICK_W-1:0] cd_sel;
  logic [cpcc_pkg::CNT_W-1:0]  load_val;
  logic                        was_on;
  logic                        fire;
  logic                        power;
  logic                        hold;
  logic [DW-1:0]               drive_wide;

  assign ch_ext   = CW'(item.channel);
  assign ch_ok    = ch_ext < CW'(NUM_COILS);
  assign hold_ok  = (ch_ext + CW'(1)) < CW'(NUM_COILS);
  assign idx      = ch_ext[IDX_W-1:0];
  assign hidx     = idx + IDX_W'(1);
  assign is_check = (kind == cpcc_pkg::KIND_SINGLE) || (kind == cpcc_pkg::KIND_PAIR);
  assign pair_ok  = (kind == cpcc_pkg::KIND_PAIR) && flipper_pair_mask[item.channel] &&
                    hold_ok;
  assign cnt_sel  = counter[idx];
  assign cd_sel   = cooldown_tbl[idx];
  assign load_val = cpcc_pkg::CNT_W'(cd_sel) + cpcc_pkg::CNT_W'(active_tbl[idx]);
  assign was_on   = drive[idx] || (pair_ok && drive[hidx]);
  assign fire     = item.request && !was_on && (cnt_sel == '0);
  assign power    = item.request &&
                    (fire || (cnt_sel > cpcc_pkg::CNT_W'(cd_sel)));
  assign hold     = pair_ok && item.request && !power && was_on;

  always_comb begin
    drive_next = drive;
    for (int i = 0; i < NUM_COILS; i++) begin
      counter_next[i] = counter[i];
      if (kind == cpcc_pkg::KIND_TICK) begin
        if (counter[i] != '0) begin
          counter_next[i] = counter[i] - cpcc_pkg::CNT_W'(1);
        end
      end else if (is_check && ch_ok && fire && (idx == IDX_W'(i))) begin
        counter_next[i] = load_val;
      end
    end
    if (is_check && ch_ok) begin
      drive_next[idx] = power;
      if (pair_ok) begin
        drive_next[hidx] = hold;
      end
    end
  end

  assign drive_wide = DW'(drive_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      drive <= '0;
      for (int i = 0; i < NUM_COILS; i++) begin
        counter[i]      <= '0;
        cooldown_tbl[i] <= '0;
        active_tbl[i]   <= '0;
      end
    end else if (advance) begin
      drive <= drive_next;
      for (int i = 0; i < NUM_COILS; i++) begin
        counter[i] <= counter_next[i];
      end
      if ((kind == cpcc_pkg::KIND_TIMING) && ch_ok) begin
        cooldown_tbl[idx] <= item.cooldown_ticks;
        active_tbl[idx]   <= item.active_ticks;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (advance) begin
      m_axis_tdata <= drive_wide[cpcc_pkg::DRIVE_W-1:0];
    end
  end

endmodule

// ===== hdl/cpcc_checker.sv =====
// port-level checker for the coil pulse and cooldown controller, with its bind
module cpcc_checker #(
  parameter int NUM_COILS = 16
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [cpcc_pkg::DRIVE_W-1:0] m_axis_tdata
);

  localparam int LIVE_N = (NUM_COILS > cpcc_pkg::DRIVE_W) ? cpcc_pkg::DRIVE_W : NUM_COILS;
  localparam logic [cpcc_pkg::DRIVE_W:0] LIVE =
    ((cpcc_pkg::DRIVE_W+1)'(1) << LIVE_N) - (cpcc_pkg::DRIVE_W+1)'(1);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_axis_tvalid)
    else $error("result item shown right after reset");

  a_no_invented_result: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> (pending != 2'd0))
    else $error("result item without an accepted input item");

  a_bounded_in_flight: assert property (@(posedge clk) disable iff (rst)
    (pending == 2'd2) |-> !s_axis_tready || m_axis_tready)
    else $error("input accepted with two items already in flight");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result item changed");

  a_no_phantom_coils: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((m_axis_tdata & ~LIVE[cpcc_pkg::DRIVE_W-1:0]) == '0))
    else $error("drive bit set for a channel that does not exist");

endmodule

bind coil_pulse_cooldown_controller_top cpcc_checker #(
  .NUM_COILS (NUM_COILS)
) u_cpcc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
